[hw/rtl/crcfr_pkg.sv]
// Shared types, codes and helpers for the CRC-16 checked frame receiver.
// No dependencies; imported by the parser, the emitter and the top level.
package crcfr_pkg;

    localparam int MAX_PAYLOAD = 32;
    localparam int STORE_DEPTH = 32;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int HDR_BYTES   = 6;
    localparam int COUNT_W     = 6;
    localparam int CFG_IDX_W   = 3;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [7:0]  CMD_SENSOR = 8'h01;
    localparam logic [7:0]  CMD_ARM    = 8'h20;
    localparam logic [15:0] LEN_SENSOR = 16'd8;
    localparam logic [15:0] LEN_ARM    = 16'd22;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_SOF  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_SOF = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_ADDR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BCAST_ADDR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_ADDR  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_ADDR = 3'd5;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_LEN  = 3'd1,
        ST_BAD_ADDR = 3'd2,
        ST_BAD_CRC  = 3'd3,
        ST_BAD_CMD  = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        PH_HUNT1 = 2'd0,
        PH_HUNT2 = 2'd1,
        PH_BODY  = 2'd2,
        PH_CRC   = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        EM_IDLE = 2'd0,
        EM_READ = 2'd1,
        EM_SHOW = 2'd2,
        EM_STAT = 2'd3
    } t_emit;

    // frame header as captured by the parser
    typedef struct packed {
        logic [7:0]  dest;
        logic [7:0]  src;
        logic [15:0] len;
        logic [7:0]  cmd;
        logic [7:0]  seq;
    } t_hdr;

    // parser -> emitter request, one-cycle pulse on go
    typedef struct packed {
        logic    go;
        logic    burst;     // good frame: stream payload from store
        t_status status;    // status for a single-result reject
        logic    zero_hdr;  // cmd/seq not yet received
    } t_req;

    // CRC-16/CCITT-FALSE, one byte, MSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[hw/rtl/crcfr_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module crcfr_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/crcfr_parser.sv]
// Byte parser: start-byte hunt, header capture, running CRC, frame checks.
// Holds the configuration registers. Depends on crcfr_pkg.
module crcfr_parser (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [crcfr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [7:0]                        i_cfg_data,
    input  logic                              i_valid,
    input  logic                              i_ready,
    input  logic [7:0]                        i_byte,
    output logic                              o_ram_we,
    output logic [crcfr_pkg::STORE_AW-1:0]    o_ram_waddr,
    output logic [7:0]                        o_ram_wdata,
    output crcfr_pkg::t_req                   o_req,
    output crcfr_pkg::t_hdr                   o_hdr
);

    import crcfr_pkg::*;

    logic [7:0] r_first_sof, r_second_sof, r_own, r_bcast, r_left, r_right;

    t_phase               r_phase, n_phase;
    logic [COUNT_W-1:0]   r_count, n_count;
    t_hdr                 r_hdr, n_hdr;
    logic [15:0]          r_crc, n_crc;
    logic [7:0]           r_crc_lo, n_crc_lo;

    logic        acc;
    logic [15:0] crc_next;
    logic [15:0] len_full;
    logic        len_too_long;
    logic [15:0] rx_crc;
    logic        addr_ok;
    t_status     chk_status;
    logic [COUNT_W-1:0] pay_idx;
    logic        pay_done;

    assign acc          = i_valid && i_ready;
    assign crc_next     = crc_byte(r_crc, i_byte);
    assign len_full     = {i_byte, r_hdr.len[7:0]};
    assign len_too_long = len_full > 16'(MAX_PAYLOAD);
    assign rx_crc       = {i_byte, r_crc_lo};
    assign pay_idx      = r_count - COUNT_W'(HDR_BYTES);
    assign pay_done     = (16'(r_count) - 16'(HDR_BYTES - 1)) >= r_hdr.len;
    assign addr_ok      = (r_hdr.dest == r_own) || (r_hdr.dest == r_bcast)
                       || (r_hdr.dest == r_left) || (r_hdr.dest == r_right);

    always_comb begin
        if (!addr_ok) begin
            chk_status = ST_BAD_ADDR;
        end else if (rx_crc != r_crc) begin
            chk_status = ST_BAD_CRC;
        end else if (r_hdr.cmd == CMD_SENSOR) begin
            chk_status = (r_hdr.len == LEN_SENSOR) ? ST_OK : ST_BAD_LEN;
        end else if (r_hdr.cmd == CMD_ARM) begin
            chk_status = (r_hdr.len == LEN_ARM) ? ST_OK : ST_BAD_LEN;
        end else begin
            chk_status = ST_BAD_CMD;
        end
    end

    // configuration; out-of-range indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_sof  <= 8'hAA;
            r_second_sof <= 8'h55;
            r_own        <= 8'h01;
            r_bcast      <= 8'hFF;
            r_left       <= 8'h02;
            r_right      <= 8'h03;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FIRST_SOF:  r_first_sof  <= i_cfg_data;
                REG_SECOND_SOF: r_second_sof <= i_cfg_data;
                REG_OWN_ADDR:   r_own        <= i_cfg_data;
                REG_BCAST_ADDR: r_bcast      <= i_cfg_data;
                REG_LEFT_ADDR:  r_left       <= i_cfg_data;
                REG_RIGHT_ADDR: r_right      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (acc) begin
            case (r_phase)
                PH_HUNT1: begin
                    if (i_byte == r_first_sof) n_phase = PH_HUNT2;
                end
                PH_HUNT2: begin
                    if (i_byte == r_second_sof) begin
                        n_phase = PH_BODY;
                    end else if (i_byte != r_first_sof) begin
                        n_phase = PH_HUNT1;
                    end
                end
                PH_BODY: begin
                    if (r_count < COUNT_W'(HDR_BYTES)) begin
                        if (r_count == 6'd3 && len_too_long) begin
                            n_phase = PH_HUNT1;
                        end else if (r_count == COUNT_W'(HDR_BYTES - 1)
                                     && r_hdr.len == 16'd0) begin
                            n_phase = PH_CRC;
                        end
                    end else if (pay_done) begin
                        n_phase = PH_CRC;
                    end
                end
                PH_CRC: begin
                    if (r_count != '0) n_phase = PH_HUNT1;
                end
                default: n_phase = PH_HUNT1;
            endcase
        end
    end

    // datapath and outputs
    always_comb begin
        n_count     = r_count;
        n_hdr       = r_hdr;
        n_crc       = r_crc;
        n_crc_lo    = r_crc_lo;
        o_ram_we    = 1'b0;
        o_ram_waddr = pay_idx[STORE_AW-1:0];
        o_ram_wdata = i_byte;
        o_req       = '{go: 1'b0, burst: 1'b0, status: ST_OK, zero_hdr: 1'b0};
        if (acc) begin
            case (r_phase)
                PH_HUNT1: ;
                PH_HUNT2: begin
                    if (i_byte == r_second_sof) begin
                        n_count = '0;
                        n_crc   = CRC_INIT;
                    end else if (i_byte != r_first_sof) begin
                        n_count = '0;
                    end
                end
                PH_BODY: begin
                    n_crc = crc_next;
                    if (r_count < COUNT_W'(HDR_BYTES)) begin
                        n_count = r_count + 1'b1;
                        case (r_count)
                            6'd0: n_hdr.dest = i_byte;
                            6'd1: n_hdr.src  = i_byte;
                            6'd2: n_hdr.len  = {8'h00, i_byte};
                            6'd3: begin
                                n_hdr.len = len_full;
                                if (len_too_long) begin
                                    n_count = '0;
                                    o_req   = '{go: 1'b1, burst: 1'b0,
                                                status: ST_BAD_LEN, zero_hdr: 1'b1};
                                end
                            end
                            6'd4: n_hdr.cmd = i_byte;
                            default: n_hdr.seq = i_byte;
                        endcase
                        if (r_count == COUNT_W'(HDR_BYTES - 1) && r_hdr.len == 16'd0) begin
                            n_count = '0;
                        end
                    end else begin
                        o_ram_we = pay_idx < COUNT_W'(STORE_DEPTH);
                        n_count  = pay_done ? '0 : r_count + 1'b1;
                    end
                end
                PH_CRC: begin
                    if (r_count == '0) begin
                        n_crc_lo = i_byte;
                        n_count  = 6'd1;
                    end else begin
                        n_count = '0;
                        o_req   = '{go: 1'b1, burst: (chk_status == ST_OK),
                                    status: chk_status, zero_hdr: 1'b0};
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT1;
            r_count  <= '0;
            r_hdr    <= '0;
            r_crc    <= CRC_INIT;
            r_crc_lo <= '0;
        end else begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_hdr    <= n_hdr;
            r_crc    <= n_crc;
            r_crc_lo <= n_crc_lo;
        end
    end

    assign o_hdr = r_hdr;

endmodule

[hw/rtl/crcfr_emit.sv]
// Result sequencer: reads the payload store and presents results.
// Depends on crcfr_pkg.
module crcfr_emit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  crcfr_pkg::t_req                   i_req,
    input  crcfr_pkg::t_hdr                   i_hdr,
    input  logic [7:0]                        i_rdata,
    input  logic                              i_res_ready,
    output logic                              o_idle,
    output logic                              o_re,
    output logic [crcfr_pkg::STORE_AW-1:0]    o_raddr,
    output logic                              o_res_valid,
    output logic [2:0]                        o_status,
    output logic [7:0]                        o_command,
    output logic [7:0]                        o_sequence_res,
    output logic [7:0]                        o_payload_byte,
    output logic [4:0]                        o_byte_position,
    output logic                              o_last
);

    import crcfr_pkg::*;

    t_emit               r_state, n_state;
    logic [STORE_AW-1:0] r_idx, n_idx;
    t_status             r_status, n_status;
    logic                r_zero, n_zero;
    logic                is_last;

    assign is_last = ({1'b0, r_idx} + 1'b1) == i_hdr.len[STORE_AW:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            EM_IDLE: begin
                if (i_req.go) n_state = i_req.burst ? EM_READ : EM_STAT;
            end
            EM_READ: n_state = EM_SHOW;
            EM_SHOW: begin
                if (i_res_ready) n_state = is_last ? EM_IDLE : EM_READ;
            end
            EM_STAT: begin
                if (i_res_ready) n_state = EM_IDLE;
            end
            default: n_state = EM_IDLE;
        endcase
    end

    always_comb begin
        n_idx    = r_idx;
        n_status = r_status;
        n_zero   = r_zero;
        if (r_state == EM_IDLE && i_req.go) begin
            n_idx    = '0;
            n_status = i_req.status;
            n_zero   = i_req.zero_hdr;
        end else if (r_state == EM_SHOW && i_res_ready) begin
            n_idx = r_idx + 1'b1;
        end
    end

    // outputs
    always_comb begin
        o_idle          = 1'b0;
        o_re            = 1'b0;
        o_res_valid     = 1'b0;
        o_status        = r_status;
        o_payload_byte  = '0;
        o_byte_position = '0;
        o_last          = 1'b1;
        case (r_state)
            EM_IDLE: o_idle = 1'b1;
            EM_READ: o_re = 1'b1;
            EM_SHOW: begin
                o_res_valid     = 1'b1;
                o_status        = ST_OK;
                o_payload_byte  = i_rdata;
                o_byte_position = 5'(r_idx);
                o_last          = is_last;
            end
            EM_STAT: o_res_valid = 1'b1;
            default: ;
        endcase
    end

    assign o_raddr        = r_idx;
    assign o_command      = r_zero ? 8'h00 : i_hdr.cmd;
    assign o_sequence_res = r_zero ? 8'h00 : i_hdr.seq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= EM_IDLE;
            r_idx    <= '0;
            r_status <= ST_OK;
            r_zero   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_status <= n_status;
            r_zero   <= n_zero;
        end
    end

endmodule

[hw/rtl/crc16_checked_frame_receiver.sv]
// Top level of the CRC-16 checked frame receiver.
// Depends on crcfr_pkg, crcfr_ram, crcfr_parser, crcfr_emit.
//
// Receives one byte per rx transfer, hunts for the two start bytes, then
// takes DEST, SRC, LEN (little endian), CMD, SEQ, the payload and a little
// endian CRC-16/CCITT-FALSE computed over DEST through the last payload
// byte. Payload bytes go into a 32 x 8 synchronous RAM as they arrive. A
// rejected frame gives a single status result (too long, bad address, bad
// CRC, bad command, wrong length for the command, checked in that order);
// a good frame gives one result per payload byte with last on the final
// one. A byte that causes no result is taken at once, and the next byte
// may follow straight away. Once a frame ends, rx ready stays low until
// all its results are transferred: a status result is shown the cycle
// after the closing byte, and each payload result takes a RAM read, then
// a present step, plus any result-side stall, so a good frame holds the
// input until every payload byte is shown. No clearing pass: the store is
// only read for entries written by the same frame. Configuration writes
// take effect at once and should be made while no frame is in progress.
module crc16_checked_frame_receiver (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [crcfr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                      i_cfg_data,
    input  logic                            i_rx_valid,
    output logic                            o_rx_ready,
    input  logic [7:0]                      i_rx_byte,
    output logic                            o_res_valid,
    input  logic                            i_res_ready,
    output logic [2:0]                      o_status,
    output logic [7:0]                      o_dest_addr,
    output logic [7:0]                      o_src_addr,
    output logic [7:0]                      o_command,
    output logic [7:0]                      o_sequence_res,
    output logic [15:0]                     o_payload_length,
    output logic [7:0]                      o_payload_byte,
    output logic [4:0]                      o_byte_position,
    output logic                            o_last
);

    import crcfr_pkg::*;

    logic                ram_we;
    logic [STORE_AW-1:0] ram_waddr;
    logic [7:0]          ram_wdata;
    logic                ram_re;
    logic [STORE_AW-1:0] ram_raddr;
    logic [7:0]          ram_rdata;
    t_req                req;
    t_hdr                hdr;
    logic                emit_idle;

    // input is held off while results of a finished frame are pending
    assign o_rx_ready = emit_idle;

    crcfr_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_rx_valid),
        .i_ready     (emit_idle),
        .i_byte      (i_rx_byte),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_req       (req),
        .o_hdr       (hdr)
    );

    // payload store
    crcfr_ram #(
        .DEPTH (STORE_DEPTH),
        .WIDTH (8)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    crcfr_emit u_emit (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req           (req),
        .i_hdr           (hdr),
        .i_rdata         (ram_rdata),
        .i_res_ready     (i_res_ready),
        .o_idle          (emit_idle),
        .o_re            (ram_re),
        .o_raddr         (ram_raddr),
        .o_res_valid     (o_res_valid),
        .o_status        (o_status),
        .o_command       (o_command),
        .o_sequence_res  (o_sequence_res),
        .o_payload_byte  (o_payload_byte),
        .o_byte_position (o_byte_position),
        .o_last          (o_last)
    );

    // header fields stay stable while results are shown: input is stalled
    assign o_dest_addr      = hdr.dest;
    assign o_src_addr       = hdr.src;
    assign o_payload_length = hdr.len;

endmodule

[verif/crcfr_checker.sv]
// Frame receiver checker: a byte-level predictor of the parser plus a result scoreboard.
// Depends on crcfr_pkg; also holds crcfr_tb_pkg, the CRC helper shared with the testbench.
`timescale 1ns / 100ps

package crcfr_tb_pkg;

    // CRC-16/CCITT-FALSE, one byte, bit-serial form
    function automatic logic [15:0] crc16_ccitt_next(input logic [15:0] crc,
                                                     input logic [7:0] data);
        logic [15:0] acc;
        logic        fb;
        acc = crc;
        for (int i = 7; i >= 0; i--) begin
            fb  = acc[15] ^ data[i];
            acc = {acc[14:0], 1'b0};
            if (fb) begin
                acc = acc ^ crcfr_pkg::CRC_POLY;
            end
        end
        return acc;
    endfunction

endpackage

module crcfr_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [crcfr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                      i_cfg_data,
    input  logic                            i_rx_valid,
    input  logic                            i_rx_ready,
    input  logic [7:0]                      i_rx_byte,
    input  logic                            i_res_valid,
    input  logic                            i_res_ready,
    input  logic [2:0]                      i_status,
    input  logic [7:0]                      i_dest_addr,
    input  logic [7:0]                      i_src_addr,
    input  logic [7:0]                      i_command,
    input  logic [7:0]                      i_sequence_res,
    input  logic [15:0]                     i_payload_length,
    input  logic [7:0]                      i_payload_byte,
    input  logic [4:0]                      i_byte_position,
    input  logic                            i_last,
    output int                              o_fail_count,
    output int                              o_pending
);
    import crcfr_pkg::*;
    import crcfr_tb_pkg::*;

    typedef struct {
        t_status     status;
        logic [7:0]  dest;
        logic [7:0]  src;
        logic [7:0]  cmd;
        logic [7:0]  seq;
        logic [15:0] len;
        logic [7:0]  pbyte;
        logic [4:0]  pos;
        logic        last;
    } t_frame_result;

    // register copies
    logic [7:0] sof1_reg, sof2_reg, own_reg, bcast_reg, left_reg, right_reg;

    // parser copy
    t_phase      rx_phase;
    logic [5:0]  body_count;
    logic [7:0]  hdr_dest, hdr_src, hdr_cmd, hdr_seq;
    logic [15:0] hdr_len;
    logic [15:0] crc_acc;
    logic [7:0]  crc_lo;
    logic [7:0]  payload_mem [STORE_DEPTH];

    t_frame_result expected_q[$];
    int            fail_total = 0;

    task automatic push_result(input t_status st, input logic [7:0] cmd, input logic [7:0] seq,
                               input logic [7:0] pbyte, input logic [4:0] pos,
                               input logic last);
        t_frame_result r;
        r.status = st;
        r.dest   = hdr_dest;
        r.src    = hdr_src;
        r.cmd    = cmd;
        r.seq    = seq;
        r.len    = hdr_len;
        r.pbyte  = pbyte;
        r.pos    = pos;
        r.last   = last;
        expected_q.push_back(r);
    endtask

    task automatic absorb_byte(input logic [7:0] b);
        logic [15:0] rx_crc;
        t_status     verdict;
        int          idx;
        case (rx_phase)
            PH_HUNT1: begin
                if (b == sof1_reg) begin
                    rx_phase = PH_HUNT2;
                end
            end
            PH_HUNT2: begin
                // second start byte wins when both registers match
                if (b == sof2_reg) begin
                    rx_phase   = PH_BODY;
                    body_count = '0;
                    crc_acc    = CRC_INIT;
                end else if (b != sof1_reg) begin
                    rx_phase   = PH_HUNT1;
                    body_count = '0;
                end
            end
            PH_BODY: begin
                crc_acc = crc16_ccitt_next(crc_acc, b);
                if (body_count < HDR_BYTES) begin
                    case (body_count)
                        0: hdr_dest = b;
                        1: hdr_src = b;
                        2: hdr_len = {8'h00, b};
                        3: hdr_len[15:8] = b;
                        4: hdr_cmd = b;
                        default: hdr_seq = b;
                    endcase
                    if (body_count == 3 && hdr_len > MAX_PAYLOAD) begin
                        // too long: reported at once, cmd/seq not yet seen
                        rx_phase   = PH_HUNT1;
                        body_count = '0;
                        push_result(ST_BAD_LEN, 8'h00, 8'h00, 8'h00, 5'd0, 1'b1);
                    end else begin
                        body_count++;
                        if (body_count == HDR_BYTES && hdr_len == 0) begin
                            rx_phase   = PH_CRC;
                            body_count = '0;
                        end
                    end
                end else begin
                    idx = body_count - HDR_BYTES;
                    if (idx < STORE_DEPTH) begin
                        payload_mem[idx] = b;
                    end
                    if (idx + 1 >= hdr_len) begin
                        rx_phase   = PH_CRC;
                        body_count = '0;
                    end else begin
                        body_count++;
                    end
                end
            end
            default: begin
                if (body_count == 0) begin
                    crc_lo     = b;
                    body_count = 6'd1;
                end else begin
                    rx_crc     = {b, crc_lo};
                    rx_phase   = PH_HUNT1;
                    body_count = '0;
                    if (hdr_dest != own_reg && hdr_dest != bcast_reg &&
                        hdr_dest != left_reg && hdr_dest != right_reg) begin
                        verdict = ST_BAD_ADDR;
                    end else if (rx_crc != crc_acc) begin
                        verdict = ST_BAD_CRC;
                    end else if (hdr_cmd == CMD_SENSOR) begin
                        verdict = (hdr_len == LEN_SENSOR) ? ST_OK : ST_BAD_LEN;
                    end else if (hdr_cmd == CMD_ARM) begin
                        verdict = (hdr_len == LEN_ARM) ? ST_OK : ST_BAD_LEN;
                    end else begin
                        verdict = ST_BAD_CMD;
                    end
                    if (verdict != ST_OK) begin
                        push_result(verdict, hdr_cmd, hdr_seq, 8'h00, 5'd0, 1'b1);
                    end else begin
                        for (int k = 0; k < hdr_len; k++) begin
                            push_result(ST_OK, hdr_cmd, hdr_seq, payload_mem[k], 5'(k),
                                        k == hdr_len - 1);
                        end
                    end
                end
            end
        endcase
    endtask

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            fail_total++;
        end
    endtask

    task automatic check_result();
        t_frame_result exp_r;
        if (expected_q.size() == 0) begin
            $error("result transfer with nothing expected (status %0d)", i_status);
            fail_total++;
        end else begin
            exp_r = expected_q.pop_front();
            compare_field("status", 16'(exp_r.status), 16'(i_status));
            compare_field("dest_addr", 16'(exp_r.dest), 16'(i_dest_addr));
            compare_field("src_addr", 16'(exp_r.src), 16'(i_src_addr));
            compare_field("command", 16'(exp_r.cmd), 16'(i_command));
            compare_field("sequence_res", 16'(exp_r.seq), 16'(i_sequence_res));
            compare_field("payload_length", exp_r.len, i_payload_length);
            compare_field("payload_byte", 16'(exp_r.pbyte), 16'(i_payload_byte));
            compare_field("byte_position", 16'(exp_r.pos), 16'(i_byte_position));
            compare_field("last", 16'(exp_r.last), 16'(i_last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sof1_reg   = 8'hAA;
            sof2_reg   = 8'h55;
            own_reg    = 8'h01;
            bcast_reg  = 8'hFF;
            left_reg   = 8'h02;
            right_reg  = 8'h03;
            rx_phase   = PH_HUNT1;
            body_count = '0;
            hdr_dest   = '0;
            hdr_src    = '0;
            hdr_len    = '0;
            hdr_cmd    = '0;
            hdr_seq    = '0;
            crc_acc    = CRC_INIT;
            crc_lo     = '0;
            expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_FIRST_SOF:  sof1_reg  = i_cfg_data;
                    REG_SECOND_SOF: sof2_reg  = i_cfg_data;
                    REG_OWN_ADDR:   own_reg   = i_cfg_data;
                    REG_BCAST_ADDR: bcast_reg = i_cfg_data;
                    REG_LEFT_ADDR:  left_reg  = i_cfg_data;
                    REG_RIGHT_ADDR: right_reg = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_res_valid && i_res_ready) begin
                check_result();
            end
            if (i_rx_valid && i_rx_ready) begin
                absorb_byte(i_rx_byte);
            end
        end
        o_pending    <= expected_q.size();
        o_fail_count <= fail_total;
    end

endmodule

[verif/testbench.sv]
// Top of the frame receiver testbench: clock, reset, byte and config stimulus, verdict.
// Depends on crcfr_pkg, crcfr_tb_pkg and crcfr_checker, plus the receiver RTL.
`timescale 1ns / 100ps

module testbench;
    import crcfr_pkg::*;
    import crcfr_tb_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transfer on either side
    localparam int DRAIN_CYCLES   = 8;     // settle time once nothing is expected
    localparam int FILLER_BYTES   = 40;    // enough to close any frame and end in the hunt

    // indexes past the last register; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    // register values after reset
    localparam logic [7:0] DEF_SOF1  = 8'hAA;
    localparam logic [7:0] DEF_SOF2  = 8'h55;
    localparam logic [7:0] DEF_OWN   = 8'h01;
    localparam logic [7:0] DEF_BCAST = 8'hFF;
    localparam logic [7:0] DEF_LEFT  = 8'h02;
    localparam logic [7:0] DEF_RIGHT = 8'h03;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]           cfg_data  = '0;
    logic                 rx_valid  = 1'b0;
    logic [7:0]           rx_byte   = '0;
    logic                 res_ready = 1'b0;
    logic                 rx_ready;
    logic                 res_valid;
    logic [2:0]           res_status;
    logic [7:0]           res_dest, res_src, res_cmd, res_seq, res_pbyte;
    logic [15:0]          res_len;
    logic [4:0]           res_pos;
    logic                 res_last;

    int fail_count;
    int pending;
    int quiet_cycles = 0;
    int frame_bytes  = 0;   // bytes sent as part of frames; noise is not counted
    bit steady       = 1'b0; // no idling on either side while set

    // the sender's view of the registers, used to build frames
    logic [7:0] sof1  = DEF_SOF1;
    logic [7:0] sof2  = DEF_SOF2;
    logic [7:0] own   = DEF_OWN;
    logic [7:0] bcast = DEF_BCAST;
    logic [7:0] left  = DEF_LEFT;
    logic [7:0] right = DEF_RIGHT;

    always #5 clk = ~clk;

    crc16_checked_frame_receiver uut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_rx_valid       (rx_valid),
        .o_rx_ready       (rx_ready),
        .i_rx_byte        (rx_byte),
        .o_res_valid      (res_valid),
        .i_res_ready      (res_ready),
        .o_status         (res_status),
        .o_dest_addr      (res_dest),
        .o_src_addr       (res_src),
        .o_command        (res_cmd),
        .o_sequence_res   (res_seq),
        .o_payload_length (res_len),
        .o_payload_byte   (res_pbyte),
        .o_byte_position  (res_pos),
        .o_last           (res_last)
    );

    crcfr_checker chk (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_rx_valid       (rx_valid),
        .i_rx_ready       (rx_ready),
        .i_rx_byte        (rx_byte),
        .i_res_valid      (res_valid),
        .i_res_ready      (res_ready),
        .i_status         (res_status),
        .i_dest_addr      (res_dest),
        .i_src_addr       (res_src),
        .i_command        (res_cmd),
        .i_sequence_res   (res_seq),
        .i_payload_length (res_len),
        .i_payload_byte   (res_pbyte),
        .i_byte_position  (res_pos),
        .i_last           (res_last),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    // One rx transfer. A gap of zero keeps valid high straight into the next byte,
    // so valid is never dropped and raised again in the same step.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            rx_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (!rx_ready);
    endtask

    // Start bytes, header, payload and CRC. A length above the maximum stops after
    // LEN, where the receiver gives up. fill < 0 means random payload bytes.
    task automatic send_frame(input logic [7:0] dest, input logic [7:0] src,
                              input logic [15:0] len, input logic [7:0] cmd,
                              input logic [7:0] seq, input logic [15:0] crc_flip,
                              input int extra_sof, input int fill);
        logic [15:0] crc;
        logic [7:0]  hdr [6];
        logic [7:0]  b;
        int          n_hdr;
        crc   = CRC_INIT;
        hdr   = '{dest, src, len[7:0], len[15:8], cmd, seq};
        n_hdr = (len > MAX_PAYLOAD) ? 4 : HDR_BYTES;
        repeat (extra_sof + 1) send_byte(sof1);
        send_byte(sof2);
        for (int i = 0; i < n_hdr; i++) begin
            crc = crc16_ccitt_next(crc, hdr[i]);
            send_byte(hdr[i]);
        end
        if (len <= MAX_PAYLOAD) begin
            for (int k = 0; k < len; k++) begin
                b   = (fill < 0) ? 8'($urandom) : fill[7:0];
                crc = crc16_ccitt_next(crc, b);
                send_byte(b);
            end
            crc = crc ^ crc_flip;
            send_byte(crc[7:0]);
            send_byte(crc[15:8]);
        end
        frame_bytes += extra_sof + 2 + n_hdr + ((len <= MAX_PAYLOAD) ? len + 2 : 0);
    endtask

    // Sender pause: hold off until every expected result has been transferred.
    task automatic drain();
        rx_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_FIRST_SOF:  sof1  = val;
            REG_SECOND_SOF: sof2  = val;
            REG_OWN_ADDR:   own   = val;
            REG_BCAST_ADDR: bcast = val;
            REG_LEFT_ADDR:  left  = val;
            REG_RIGHT_ADDR: right = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Close whatever frame is open with a byte that can start nothing, wait for the
    // results, then rewrite every register (plus the unused indexes).
    task automatic apply_settings(input logic [7:0] s1, input logic [7:0] s2,
                                  input logic [7:0] a_own, input logic [7:0] a_bcast,
                                  input logic [7:0] a_left, input logic [7:0] a_right);
        logic [7:0] filler;
        filler = 8'h00;
        while (filler == sof1 || filler == sof2) filler++;
        repeat (FILLER_BYTES) send_byte(filler);
        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        set_reg(REG_SPARE_LO, 8'($urandom));
        set_reg(REG_FIRST_SOF, s1);
        set_reg(REG_SECOND_SOF, s2);
        set_reg(REG_OWN_ADDR, a_own);
        set_reg(REG_BCAST_ADDR, a_bcast);
        set_reg(REG_LEFT_ADDR, a_left);
        set_reg(REG_RIGHT_ADDR, a_right);
        set_reg(REG_SPARE_HI, 8'($urandom));
        cfg_we <= 1'b0;
    endtask

    // Mostly well-formed frames with random content; the rest broken in one way.
    task automatic random_frame();
        logic [7:0]  addrs [4];
        logic [7:0]  dest, cmd;
        logic [15:0] len, good_len;
        logic [15:0] flip;
        int          reps;
        int          kind;
        addrs = '{own, bcast, left, right};
        dest  = addrs[2'($urandom_range(0, 3))];
        if ($urandom_range(0, 1) == 0) begin
            cmd = CMD_SENSOR;
            len = LEN_SENSOR;
        end else begin
            cmd = CMD_ARM;
            len = LEN_ARM;
        end
        good_len = len;
        flip     = 16'h0000;
        reps     = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0;
        kind     = $urandom_range(0, 19);
        case (kind)
            12: flip = 16'($urandom_range(1, 16'hFFFF));
            13: begin
                do dest = 8'($urandom); while (dest == own || dest == bcast ||
                                               dest == left || dest == right);
            end
            14: begin
                do cmd = 8'($urandom); while (cmd == CMD_SENSOR || cmd == CMD_ARM);
                len = 16'($urandom_range(0, MAX_PAYLOAD));
            end
            15: begin
                do len = 16'($urandom_range(0, MAX_PAYLOAD)); while (len == good_len);
            end
            16: len = 16'($urandom_range(MAX_PAYLOAD + 1, 16'hFFFF));
            17: begin
                repeat ($urandom_range(1, 8)) send_byte(8'($urandom));
                return;
            end
            18: begin
                // start byte followed by anything
                send_byte(sof1);
                send_byte(8'($urandom));
                return;
            end
            19: begin
                len = 16'd0;
                cmd = ($urandom_range(0, 1) == 0) ? CMD_SENSOR : 8'($urandom);
            end
            default: ;
        endcase
        send_frame(dest, 8'($urandom), len, cmd, 8'($urandom), flip, reps, -1);
    endtask

    task automatic run_random(input int target);
        int start;
        start = frame_bytes;
        while (frame_bytes - start < target) begin
            if ($urandom_range(0, 4) == 0) steady = ~steady;
            if ($urandom_range(0, 7) == 0) drain();
            random_frame();
        end
        steady = 1'b0;
    endtask

    // Result side: random stall before each transfer, none while steady is set.
    initial begin
        int stall;
        forever begin
            stall = steady ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                res_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ready <= 1'b1;
            do @(posedge clk); while (!res_valid);
        end
    end

    // Watchdog: too long with no transfer on either channel means a hang.
    always @(posedge clk) begin
        if (!rst_n || (rx_valid && rx_ready) || (res_valid && res_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("[crc16_checked_frame_receiver] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [7:0] v;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed frames, reset register values
        send_byte(sof1);          // start byte, then a break back to the hunt
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(own, 8'h00, LEN_SENSOR, CMD_SENSOR, 8'h00, 16'h0000, 0, 8'h00);
        send_frame(bcast, 8'hFF, LEN_ARM, CMD_ARM, 8'hFF, 16'h0000, 0, 8'hFF);
        // repeated first start byte keeps the hunt for the second
        send_frame(left, 8'h5A, LEN_SENSOR, CMD_SENSOR, 8'h11, 16'h0000, 2, -1);
        send_frame(right, 8'hA5, LEN_ARM, CMD_ARM, 8'h22, 16'h0000, 0, -1);
        send_frame(8'h7E, 8'h01, LEN_SENSOR, CMD_SENSOR, 8'h33, 16'h0000, 0, -1);
        send_frame(own, 8'h02, LEN_SENSOR, CMD_SENSOR, 8'h44, 16'h0001, 0, -1);
        send_frame(own, 8'h03, LEN_ARM, CMD_ARM, 8'h45, 16'h8000, 0, -1);
        send_frame(own, 8'h04, 16'd5, 8'h00, 8'h55, 16'h0000, 0, -1);
        send_frame(bcast, 8'h05, 16'd0, 8'hFF, 8'h66, 16'h0000, 0, -1);
        send_frame(own, 8'h06, LEN_ARM, CMD_SENSOR, 8'h77, 16'h0000, 0, -1);
        send_frame(own, 8'h07, LEN_SENSOR, CMD_ARM, 8'h88, 16'h0000, 0, -1);
        // empty payload goes straight to the CRC bytes
        send_frame(own, 8'h08, 16'd0, CMD_SENSOR, 8'h99, 16'h0000, 0, -1);
        send_frame(own, 8'h09, 16'd0, CMD_SENSOR, 8'h9A, 16'h1234, 0, -1);
        send_frame(own, 8'h0A, 16'(MAX_PAYLOAD), CMD_ARM, 8'hAB, 16'h0000, 0, -1);
        // too long: rejected right after the LEN high byte
        send_frame(own, 8'h0B, 16'(MAX_PAYLOAD + 1), CMD_ARM, 8'h00, 16'h0000, 0, -1);
        send_frame(own, 8'h0C, 16'hFFFF, CMD_ARM, 8'h00, 16'h0000, 0, -1);
        send_frame(own, 8'h0D, 16'h0100, CMD_SENSOR, 8'h00, 16'h0000, 0, -1);
        run_random(25);

        // extreme register values
        apply_settings(8'h00, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'h7F);
        send_frame(8'h00, 8'hFF, LEN_SENSOR, CMD_SENSOR, 8'hFF, 16'h0000, 0, 8'hFF);
        send_frame(8'h7F, 8'h00, LEN_ARM, CMD_ARM, 8'h00, 16'h0000, 1, 8'h00);
        run_random(25);

        // both start registers equal: the byte counts as the second one
        v = 8'($urandom);
        apply_settings(v, v, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        send_frame(own, 8'h21, LEN_SENSOR, CMD_SENSOR, 8'h31, 16'h0000, 0, -1);
        send_frame(bcast, 8'h22, LEN_ARM, CMD_ARM, 8'h32, 16'h0000, 1, -1);
        run_random(25);

        // back to the reset values, written explicitly
        apply_settings(DEF_SOF1, DEF_SOF2, DEF_OWN, DEF_BCAST, DEF_LEFT, DEF_RIGHT);
        run_random(25);

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("[crc16_checked_frame_receiver] OK");
        end else begin
            $display("[crc16_checked_frame_receiver] ERROR");
        end
        $finish;
    end

endmodule
